@@ rtl/cplx_pkg.sv @@
// Shared types and constants for the complex accumulator ALU.
package cplx_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;

   typedef enum logic [2:0] {
      CMD_LOAD = 3'd0,
      CMD_MAG  = 3'd1,
      CMD_ADD  = 3'd2,
      CMD_SUB  = 3'd3,
      CMD_MUL  = 3'd4,
      CMD_DIV  = 3'd5
   } cmd_type;

endpackage

@@ rtl/complex_accumulator_alu_top.sv @@
// Complex accumulator ALU: bit-serial multiply, divide and square root over a held value.
// Steps: load/add/sub/mag run serial squares, then a 2-bit-a-cycle square root;
// multiply first runs shift-add products (one multiplier bit a cycle per product pair);
// divide first forms the products, then restoring-divides for the two quotients.
// One item at a time; the next item is taken once the previous result is in the output register.
// Reset (synchronous, active high) clears the held value to zero and empties the output register.
module complex_accumulator_alu_top
   import cplx_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // command[2:0], operand_real, operand_imag, zero pad to bytes
   input  logic [((3+2*DATA_WIDTH+7)/8)*8-1:0] req_tdata,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // result_real, result_imag, magnitude, zero pad to bytes
   output logic [((3*DATA_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // divide_by_zero
   output logic rsp_tuser
);
   localparam int DW  = DATA_WIDTH;
   localparam int PW  = 2*DW+2;            // product/sum width, signed
   localparam int NW  = PW + FRAC_BITS;    // dividend width incl. scaling
   localparam int CW  = $clog2(NW+2);
   localparam int RW  = ((3*DW+7)/8)*8;
   localparam int IW  = ((3+2*DW+7)/8)*8;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_MSUM, ST_DDEN, ST_DIV, ST_DNEXT, ST_SQ, ST_SQRT, ST_OUT
   } state_type;

   state_type state_ff, state_in;

   logic signed [DW-1:0] cur_re_ff, cur_re_in, cur_im_ff, cur_im_in;
   logic signed [DW-1:0] op_c_ff, op_c_in, op_d_ff, op_d_in;
   cmd_type cmd_ff, cmd_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0] pass_ff, pass_in;
   // serial multiplier: two products at a time, sharing multiplier bits of mq
   logic [DW-1:0] mq_ff, mq_in;                 // multiplier magnitude, shifts right
   logic [PW-1:0] macc1_ff, macc1_in, macc2_ff, macc2_in;
   logic [PW-1:0] mcand1_ff, mcand1_in, mcand2_ff, mcand2_in;
   logic          mneg_ff, mneg_in;             // multiplier sign
   logic signed [PW-1:0] p1_ff, p1_in, p2_ff, p2_in;   // finished signed products
   logic signed [PW-1:0] den_ff, den_in;
   // restoring divider
   logic [NW-1:0] dq_ff, dq_in;
   logic [PW:0]   drem_ff, drem_in;
   logic          dneg_ff, dneg_in;
   logic signed [DW-1:0] qre_ff, qre_in;
   // square root, two bits a cycle from the top
   logic [PW-1:0] sv_ff, sv_in;
   logic [PW+1:0] srem_ff, srem_in;
   logic [DW:0]   sroot_ff, sroot_in;
   logic dz_ff, dz_in;
   logic [RW-1:0] out_ff, out_in;
   logic ovalid_ff, ovalid_in, ouser_ff, ouser_in;

   logic [2:0] in_cmd;
   logic signed [DW-1:0] in_c, in_d;
   assign in_cmd = req_tdata[2:0];
   assign in_c   = req_tdata[3 +: DW];
   assign in_d   = req_tdata[3+DW +: DW];

   localparam logic signed [PW-1:0] MAXP = PW'((64'sd1 <<< (DW-1)) - 1);
   localparam logic signed [PW-1:0] MINP = -PW'(64'sd1 <<< (DW-1));

   function automatic logic [DW-1:0] sat(input logic signed [PW-1:0] v);
      logic [DW-1:0] r;
      if (v > MAXP) r = MAXP[DW-1:0];
      else if (v < MINP) r = MINP[DW-1:0];
      else r = v[DW-1:0];
      return r;
   endfunction

   function automatic logic [DW-1:0] absv(input logic signed [DW-1:0] v);
      return v[DW-1] ? DW'(-v) : DW'(v);
   endfunction

   // signed products, pass chooses operands; pass 0/1 mult, pass 2 c*c, pass 3 d*d
   logic signed [DW-1:0] ma, mb1, mb2;
   always_comb begin
      case (pass_ff)
         2'd0:    begin ma = op_c_ff; mb1 = cur_re_ff; mb2 = cur_im_ff; end
         2'd1:    begin ma = op_d_ff; mb1 = cur_re_ff; mb2 = cur_im_ff; end
         2'd2:    begin ma = op_c_ff; mb1 = op_c_ff; mb2 = op_d_ff; end
         default: begin ma = op_d_ff; mb1 = op_d_ff; mb2 = op_c_ff; end
      endcase
   end

   logic [PW:0] dtrial;
   logic [PW+1:0] strial;
   logic signed [PW-1:0] mres1, mres2, num_s, sum_sq;
   logic [PW-1:0] num_mag;
   logic [DW-1:0] q_sat;
   logic signed [PW:0] s_re, s_im;
   logic signed [PW-1:0] fl_re;

   always_comb begin
      state_in = state_ff; cur_re_in = cur_re_ff; cur_im_in = cur_im_ff;
      op_c_in = op_c_ff; op_d_in = op_d_ff; cmd_in = cmd_ff; cnt_in = cnt_ff;
      pass_in = pass_ff; mq_in = mq_ff; macc1_in = macc1_ff; macc2_in = macc2_ff;
      mcand1_in = mcand1_ff; mcand2_in = mcand2_ff; mneg_in = mneg_ff;
      p1_in = p1_ff; p2_in = p2_ff; den_in = den_ff; dq_in = dq_ff; drem_in = drem_ff;
      dneg_in = dneg_ff; qre_in = qre_ff; sv_in = sv_ff; srem_in = srem_ff;
      sroot_in = sroot_ff; dz_in = dz_ff; out_in = out_ff; ouser_in = ouser_ff;
      ovalid_in = ovalid_ff && !rsp_tready;
      dtrial = '0; strial = '0; mres1 = '0; mres2 = '0; num_s = '0; num_mag = '0;
      q_sat = '0; s_re = '0; s_im = '0; fl_re = '0; sum_sq = '0;
      case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            cmd_in = cmd_type'(in_cmd); op_c_in = in_c; op_d_in = in_d; dz_in = 1'b0;
            s_re = (PW+1)'(cur_re_ff) + ((in_cmd == CMD_SUB) ? -(PW+1)'(in_c) : (PW+1)'(in_c));
            s_im = (PW+1)'(cur_im_ff) + ((in_cmd == CMD_SUB) ? -(PW+1)'(in_d) : (PW+1)'(in_d));
            state_in = ST_SQ;
            case (in_cmd)
               CMD_LOAD: begin cur_re_in = in_c; cur_im_in = in_d; end
               CMD_ADD, CMD_SUB: begin
                  cur_re_in = sat(s_re[PW-1:0]); cur_im_in = sat(s_im[PW-1:0]);
               end
               CMD_MUL, CMD_DIV: begin
                  if (in_cmd == CMD_DIV && in_c == '0 && in_d == '0) dz_in = 1'b1;
                  else begin
                     pass_in = (in_cmd == CMD_DIV) ? 2'd2 : 2'd0;
                     state_in = ST_MUL; cnt_in = '0;
                     // loaded next cycle through ST_MUL with cnt DW+1 start
                  end
               end
               default: ;
            endcase
            if (state_in == ST_MUL) begin
               // initial load happens in ST_MUL when cnt==DW+1, set below
               mq_in = '0; macc1_in = '0; macc2_in = '0;
               mneg_in = 1'b0; mcand1_in = '0; mcand2_in = '0;
               cnt_in = CW'(DW+1);
            end
         end
         ST_MUL: begin
            if (cnt_ff == CW'(DW+1)) begin
               // set up this pass
               mq_in = absv(ma); mneg_in = ma[DW-1];
               mcand1_in = PW'(mb1); mcand2_in = PW'(mb2);
               macc1_in = '0; macc2_in = '0; cnt_in = CW'(DW);
            end else if (cnt_ff != '0) begin
               if (mq_ff[0]) begin
                  macc1_in = macc1_ff + mcand1_ff; macc2_in = macc2_ff + mcand2_ff;
               end
               mq_in = mq_ff >> 1; mcand1_in = mcand1_ff << 1; mcand2_in = mcand2_ff << 1;
               cnt_in = cnt_ff - 1'b1;
            end else begin
               mres1 = mneg_ff ? -$signed(macc1_ff) : $signed(macc1_ff);
               mres2 = mneg_ff ? -$signed(macc2_ff) : $signed(macc2_ff);
               case (pass_ff)
                  2'd0: begin p1_in = mres1; p2_in = mres2; pass_in = 2'd1;
                     cnt_in = CW'(DW+1); end
                  2'd1: state_in = ST_MSUM;         // mres1=a*d, mres2=b*d
                  2'd2: begin den_in = mres1; pass_in = 2'd3; cnt_in = CW'(DW+1); end
                  default: begin den_in = den_ff + mres1; state_in = ST_DDEN; end
               endcase
               if (pass_ff == 2'd1) begin
                  op_c_in = op_c_ff; // keep
                  p1_in = p1_ff; p2_in = p2_ff;
                  // stash ad, bd in mcand regs for later use
                  mcand1_in = PW'(mres1); mcand2_in = PW'(mres2);
               end
            end
         end
         ST_MSUM: begin
            // p1=a*c p2=b*c mcand1=a*d mcand2=b*d
            if (cmd_ff == CMD_MUL) begin
               fl_re = (p1_ff - $signed(mcand2_ff)) >>> FRAC_BITS;
               cur_re_in = sat(fl_re);
               fl_re = ($signed(mcand1_ff) + p2_ff) >>> FRAC_BITS;
               cur_im_in = sat(fl_re);
               state_in = ST_SQ;
            end else begin
               pass_in = 2'd0; state_in = ST_DNEXT; // first numerator: ac+bd
               num_s = p1_ff + $signed(mcand2_ff);
               dneg_in = num_s[PW-1];
               num_mag = num_s[PW-1] ? PW'(-num_s) : PW'(num_s);
               dq_in = {num_mag, {FRAC_BITS{1'b0}}}; drem_in = '0; cnt_in = CW'(NW);
            end
         end
         ST_DDEN: begin
            // den ready, now do the cross products
            pass_in = 2'd0; cnt_in = CW'(DW+1); state_in = ST_MUL;
         end
         ST_DNEXT: state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff != '0) begin
               dtrial = {drem_ff[PW-1:0], dq_ff[NW-1]} - {1'b0, den_ff};
               if (!dtrial[PW]) begin drem_in = dtrial; dq_in = {dq_ff[NW-2:0], 1'b1}; end
               else begin drem_in = {drem_ff[PW-1:0], dq_ff[NW-1]}; dq_in = {dq_ff[NW-2:0], 1'b0}; end
               cnt_in = cnt_ff - 1'b1;
            end else begin
               if (dq_ff > NW'(MAXP)) q_sat = dneg_ff ? MINP[DW-1:0] : MAXP[DW-1:0];
               else q_sat = dneg_ff ? DW'(-dq_ff[DW-1:0]) : dq_ff[DW-1:0];
               if (dneg_ff && dq_ff == NW'(MAXP) + 1'b1) q_sat = MINP[DW-1:0];
               if (pass_ff == 2'd0) begin
                  qre_in = q_sat; pass_in = 2'd1;
                  num_s = p2_ff - $signed(mcand1_ff);   // bc - ad
                  dneg_in = num_s[PW-1];
                  num_mag = num_s[PW-1] ? PW'(-num_s) : PW'(num_s);
                  dq_in = {num_mag, {FRAC_BITS{1'b0}}}; drem_in = '0; cnt_in = CW'(NW);
               end else begin
                  cur_re_in = qre_ff; cur_im_in = q_sat; state_in = ST_SQ;
               end
            end
         end
         ST_SQ: begin
            // squares via multiplier pass 2 is overkill; reuse serial path
            pass_in = 2'd3; cnt_in = CW'(DW+1); state_in = ST_SQRT;
            mq_in = absv(cur_re_ff); mcand1_in = PW'(absv(cur_re_ff));
            mcand2_in = PW'(absv(cur_im_ff)); mneg_in = 1'b0;
            macc1_in = '0; macc2_in = '0; sroot_in = '0;
            p1_in = '0;
         end
         ST_SQRT: begin
            // phase A (pass 3): re^2 then im^2 serially; phase B (pass 2): sqrt
            if (pass_ff == 2'd3) begin
               if (cnt_ff > 1) begin
                  if (mq_ff[0]) macc1_in = macc1_ff + mcand1_ff;
                  mq_in = mq_ff >> 1; mcand1_in = mcand1_ff << 1; cnt_in = cnt_ff - 1'b1;
               end else if (p1_ff == '0) begin
                  p1_in = PW'(1); p2_in = $signed(macc1_ff);
                  macc1_in = '0; mq_in = absv(cur_im_ff); mcand1_in = mcand2_ff;
                  cnt_in = CW'(DW+1);
               end else begin
                  sum_sq = p2_ff + $signed(macc1_ff);
                  sv_in = sum_sq; srem_in = '0; sroot_in = '0;
                  pass_in = 2'd2; cnt_in = CW'(PW/2);
               end
            end else if (cnt_ff != '0) begin
               strial = {srem_ff[PW-1:0], sv_ff[PW-1 -: 2]} - {sroot_ff, 2'b01};
               if (!strial[PW+1]) begin
                  srem_in = strial; sroot_in = {sroot_ff[DW-1:0], 1'b1};
               end else begin
                  srem_in = {srem_ff[PW-1:0], sv_ff[PW-1 -: 2]};
                  sroot_in = {sroot_ff[DW-1:0], 1'b0};
               end
               sv_in = sv_ff << 2; cnt_in = cnt_ff - 1'b1;
            end else state_in = ST_OUT;
         end
         ST_OUT: if (!ovalid_ff || rsp_tready) begin
            out_in = RW'({sroot_ff[DW-1:0], cur_im_ff, cur_re_ff});
            ouser_in = dz_ff; ovalid_in = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; cur_re_ff <= '0; cur_im_ff <= '0; ovalid_ff <= 1'b0;
         cnt_ff <= '0; pass_ff <= '0;
      end else begin
         state_ff <= state_in; cur_re_ff <= cur_re_in; cur_im_ff <= cur_im_in;
         ovalid_ff <= ovalid_in; cnt_ff <= cnt_in; pass_ff <= pass_in;
      end
      op_c_ff <= op_c_in; op_d_ff <= op_d_in; cmd_ff <= cmd_in; mq_ff <= mq_in;
      macc1_ff <= macc1_in; macc2_ff <= macc2_in; mcand1_ff <= mcand1_in;
      mcand2_ff <= mcand2_in; mneg_ff <= mneg_in; p1_ff <= p1_in; p2_ff <= p2_in;
      den_ff <= den_in; dq_ff <= dq_in; drem_ff <= drem_in; dneg_ff <= dneg_in;
      qre_ff <= qre_in; sv_ff <= sv_in; srem_ff <= srem_in; sroot_ff <= sroot_in;
      dz_ff <= dz_in; out_ff <= out_in; ouser_ff <= ouser_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tuser  = ouser_ff;

   logic unused_pad;
   assign unused_pad = ^{req_tdata[IW-1:3+2*DW]};

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while busy");
   a_dz: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> $stable(cur_re_ff) || state_ff != ST_IDLE)
      else $error("divide by zero altered value");
endmodule
